[rtl/core/charge_direction_controller_macros.svh]
// Assertion macros shared by the charge direction controller modules.
`ifndef CHARGE_DIRECTION_CONTROLLER_MACROS_SVH
`define CHARGE_DIRECTION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge while reset is released.
`define CDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds while reset is released.
`define CDC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CDC_ASSERT(label, clk, rst_n, prop, msg)
`define CDC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/core/cdc_pkg.sv]
package cdc_pkg;

    // Direction codes, also used for the sensed line.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // Reported charge states.
    localparam logic [2:0] ST_FWD      = 3'd0;
    localparam logic [2:0] ST_BWD      = 3'd1;
    localparam logic [2:0] ST_AUTO_FWD = 3'd2;
    localparam logic [2:0] ST_AUTO_BWD = 3'd3;
    localparam logic [2:0] ST_MAN_FWD  = 3'd4;
    localparam logic [2:0] ST_MAN_BWD  = 3'd5;

    // Charge setting codes.
    localparam logic [2:0] SET_FWD    = 3'd0;
    localparam logic [2:0] SET_BWD    = 3'd1;
    localparam logic [2:0] SET_AUTO   = 3'd2;
    localparam logic [2:0] SET_MANUAL = 3'd3;
    localparam logic [2:0] SET_KEY    = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CHARGE_SETTING   = 3'd0;
    localparam logic [2:0] CFG_AUTO_EXIT_IN     = 3'd1;
    localparam logic [2:0] CFG_AUTO_ENTER_IN    = 3'd2;
    localparam logic [2:0] CFG_INPUT_UNDERVOLT  = 3'd3;
    localparam logic [2:0] CFG_AUTO_ENTER_OUT   = 3'd4;
    localparam logic [2:0] CFG_ACC_FORWARD      = 3'd5;
    localparam logic [2:0] CFG_ACC_REVERSE      = 3'd6;
    localparam logic [2:0] CFG_REMOTE_REVERSE   = 3'd7;

    localparam logic [3:0] EXIT_DELAY_TICKS = 4'd10;

    typedef enum logic [2:0] {
        K_TICK,
        K_FIX_FWD,
        K_FIX_BWD,
        K_AUTO,
        K_MANUAL,
        K_HOLD
    } t_kind;

    // One classified request handed from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic       exit_hit;
        logic       enter_hit;
        logic [1:0] host;
        logic [1:0] acc_dir;
        logic       rev;
        logic       lock;
    } t_cmd;

endpackage

[rtl/core/cdc_front.sv]
module cdc_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_mode,
    input  logic [1:0]   i_host_direction,
    input  logic [15:0]  i_input_volt,
    input  logic [15:0]  i_output_volt,
    input  logic [15:0]  i_accessory_volt,
    input  logic [15:0]  i_remote_volt,
    input  logic         i_key_level,
    input  logic         i_timeout_lock,
    output cdc_pkg::t_cmd o_cmd
);
    import cdc_pkg::*;

    logic [2:0]  r_charge_setting;
    logic [15:0] r_auto_exit_in;
    logic [15:0] r_auto_enter_in;
    logic [15:0] r_input_undervolt;
    logic [15:0] r_auto_enter_out;
    logic [15:0] r_acc_forward;
    logic [15:0] r_acc_reverse;
    logic [15:0] r_remote_reverse;

    logic rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_setting  <= SET_FWD;
            r_auto_exit_in    <= '0;
            r_auto_enter_in   <= '0;
            r_input_undervolt <= '0;
            r_auto_enter_out  <= '0;
            r_acc_forward     <= '0;
            r_acc_reverse     <= '0;
            r_remote_reverse  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHARGE_SETTING:  r_charge_setting  <= i_cfg_data[2:0];
                CFG_AUTO_EXIT_IN:    r_auto_exit_in    <= i_cfg_data;
                CFG_AUTO_ENTER_IN:   r_auto_enter_in   <= i_cfg_data;
                CFG_INPUT_UNDERVOLT: r_input_undervolt <= i_cfg_data;
                CFG_AUTO_ENTER_OUT:  r_auto_enter_out  <= i_cfg_data;
                CFG_ACC_FORWARD:     r_acc_forward     <= i_cfg_data;
                CFG_ACC_REVERSE:     r_acc_reverse     <= i_cfg_data;
                CFG_REMOTE_REVERSE:  r_remote_reverse  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign rev = (i_accessory_volt < r_acc_reverse) && (i_remote_volt > r_remote_reverse);

    always_comb begin
        o_cmd.exit_hit  = i_input_volt > r_auto_exit_in;
        o_cmd.enter_hit = (i_input_volt < r_auto_enter_in) &&
                          (i_input_volt > r_input_undervolt) &&
                          (i_output_volt > r_auto_enter_out);
        o_cmd.host      = i_host_direction;
        o_cmd.rev       = rev;
        o_cmd.lock      = i_timeout_lock;
        // A forward accessory request wins over a reverse one.
        if (i_accessory_volt > r_acc_forward) begin
            o_cmd.acc_dir = DIR_FWD;
        end else if (rev) begin
            o_cmd.acc_dir = DIR_BWD;
        end else begin
            o_cmd.acc_dir = DIR_NONE;
        end

        if (i_mode) begin
            o_cmd.kind = K_TICK;
        end else begin
            case (r_charge_setting)
                SET_FWD:    o_cmd.kind = (i_host_direction == DIR_BWD) ? K_FIX_BWD : K_FIX_FWD;
                SET_BWD:    o_cmd.kind = (i_host_direction == DIR_FWD) ? K_FIX_FWD : K_FIX_BWD;
                SET_AUTO:   o_cmd.kind = K_AUTO;
                SET_MANUAL: o_cmd.kind = K_MANUAL;
                SET_KEY:    o_cmd.kind = i_key_level ? K_MANUAL : K_AUTO;
                default:    o_cmd.kind = K_HOLD;
            endcase
        end
    end

endmodule

[rtl/core/cdc_queue.sv]
`include "charge_direction_controller_macros.svh"

module cdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cdc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cdc_pkg::t_cmd o_data
);
    import cdc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CDC_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count == 2'd3, "queue count out of range")
    `CDC_ASSERT(a_ptr_match, i_clk, i_rst_n, (r_count != 2'd1) |-> (r_wr_ptr == r_rd_ptr), "queue pointers disagree with count")

endmodule

[rtl/core/cdc_back.sv]
`include "charge_direction_controller_macros.svh"

module cdc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  cdc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [2:0]    o_charge_state,
    output logic [1:0]    o_sense_select,
    output logic          o_write_valid,
    output logic [1:0]    o_write_direction,
    output logic          o_reverse_entered
);
    import cdc_pkg::*;

    logic       r_auto_flag, n_auto_flag;
    logic       r_mon, n_mon;
    logic [1:0] r_last_host, n_last_host;
    logic [1:0] r_last_acc, n_last_acc;
    logic       r_last_rev, n_last_rev;
    logic [1:0] r_act, n_act;
    logic [1:0] r_app, n_app;
    logic [3:0] r_edc, n_edc;
    logic [2:0] r_held_state, n_held_state;
    logic [1:0] r_held_sense, n_held_sense;
    logic       r_out_valid;
    logic       r_wr_valid, n_wr_valid;
    logic [1:0] r_wr_dir, n_wr_dir;
    logic       r_rev_pulse, n_rev_pulse;

    // The held state is the result payload; it only moves on a pop, which
    // never happens while a result is stalled.
    assign o_pop             = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid       = r_out_valid;
    assign o_charge_state    = r_held_state;
    assign o_sense_select    = r_held_sense;
    assign o_write_valid     = r_wr_valid;
    assign o_write_direction = r_wr_dir;
    assign o_reverse_entered = r_rev_pulse;

    always_comb begin
        n_auto_flag  = r_auto_flag;
        n_mon        = r_mon;
        n_last_host  = r_last_host;
        n_last_acc   = r_last_acc;
        n_last_rev   = r_last_rev;
        n_act        = r_act;
        n_app        = r_app;
        n_edc        = r_edc;
        n_held_state = r_held_state;
        n_held_sense = r_held_sense;
        n_wr_valid   = 1'b0;
        n_wr_dir     = DIR_NONE;
        n_rev_pulse  = 1'b0;

        case (i_cmd.kind)
            K_TICK: begin
                if (r_app != DIR_BWD || r_act == DIR_BWD) begin
                    n_edc = 4'd0;
                end else if (r_edc == 4'd0) begin
                    n_edc = EXIT_DELAY_TICKS;
                end else begin
                    n_edc = r_edc - 4'd1;
                    if (r_edc == 4'd1) begin
                        n_app = DIR_FWD;
                    end
                end
            end
            K_FIX_FWD: begin
                n_held_state = ST_FWD;
                n_held_sense = DIR_FWD;
            end
            K_FIX_BWD: begin
                n_held_state = ST_BWD;
                n_held_sense = DIR_BWD;
            end
            K_AUTO: begin
                if (r_auto_flag) begin
                    if (i_cmd.exit_hit) begin
                        n_auto_flag = 1'b0;
                    end
                    n_held_state = ST_AUTO_BWD;
                    n_held_sense = DIR_BWD;
                end else begin
                    if (i_cmd.enter_hit) begin
                        n_auto_flag = 1'b1;
                    end
                    n_held_state = ST_AUTO_FWD;
                    n_held_sense = DIR_FWD;
                end
            end
            K_MANUAL: begin
                if (!r_mon) begin
                    // First manual evaluation seeds the change trackers.
                    n_mon       = 1'b1;
                    n_last_host = i_cmd.host;
                    n_last_acc  = i_cmd.acc_dir;
                    n_last_rev  = i_cmd.rev;
                    if (i_cmd.acc_dir != DIR_NONE) begin
                        n_wr_valid  = 1'b1;
                        n_wr_dir    = i_cmd.acc_dir;
                        n_last_host = i_cmd.acc_dir;
                        n_act       = i_cmd.acc_dir;
                        n_rev_pulse = (i_cmd.acc_dir == DIR_BWD);
                    end else if (i_cmd.host == DIR_FWD || i_cmd.host == DIR_BWD) begin
                        n_act = i_cmd.host;
                    end else begin
                        n_act = DIR_FWD;
                    end
                    n_app = n_act;
                end else begin
                    if (i_cmd.host != r_last_host) begin
                        n_last_host = i_cmd.host;
                        if (i_cmd.host == DIR_FWD || i_cmd.host == DIR_BWD) begin
                            n_act = i_cmd.host;
                        end else if (i_cmd.acc_dir != DIR_NONE) begin
                            n_act = i_cmd.acc_dir;
                        end else begin
                            n_act = DIR_FWD;
                        end
                    end
                    if (i_cmd.acc_dir != r_last_acc) begin
                        n_last_acc = i_cmd.acc_dir;
                        n_last_rev = i_cmd.rev;
                        if (i_cmd.acc_dir != DIR_NONE) begin
                            n_wr_valid  = 1'b1;
                            n_wr_dir    = i_cmd.acc_dir;
                            n_last_host = i_cmd.acc_dir;
                            n_act       = i_cmd.acc_dir;
                            n_rev_pulse = (i_cmd.acc_dir == DIR_BWD);
                        end else if (n_act == DIR_BWD) begin
                            n_wr_valid  = 1'b1;
                            n_wr_dir    = DIR_FWD;
                            n_last_host = DIR_FWD;
                            n_act       = DIR_FWD;
                        end
                    end else if (i_cmd.rev != r_last_rev) begin
                        n_last_rev = i_cmd.rev;
                        if (i_cmd.rev) begin
                            n_wr_valid  = 1'b1;
                            n_wr_dir    = DIR_BWD;
                            n_last_host = DIR_BWD;
                            n_act       = DIR_BWD;
                            n_rev_pulse = 1'b1;
                        end else if (n_act == DIR_BWD) begin
                            n_wr_valid  = 1'b1;
                            n_wr_dir    = DIR_FWD;
                            n_last_host = DIR_FWD;
                            n_act       = DIR_FWD;
                        end
                    end
                end

                if (i_cmd.lock && i_cmd.rev) begin
                    n_app        = DIR_FWD;
                    n_edc        = 4'd0;
                    n_held_state = ST_MAN_FWD;
                    n_held_sense = DIR_FWD;
                end else begin
                    if (n_act == DIR_BWD) begin
                        n_app = DIR_BWD;
                        n_edc = 4'd0;
                    end else if (n_app != DIR_BWD) begin
                        n_app = DIR_FWD;
                    end
                    if (n_app == DIR_BWD) begin
                        n_held_state = ST_MAN_BWD;
                        n_held_sense = DIR_BWD;
                    end else begin
                        n_held_state = ST_MAN_FWD;
                        n_held_sense = DIR_FWD;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_flag  <= 1'b0;
            r_mon        <= 1'b0;
            r_last_host  <= DIR_NONE;
            r_last_acc   <= DIR_NONE;
            r_last_rev   <= 1'b0;
            r_act        <= DIR_NONE;
            r_app        <= DIR_NONE;
            r_edc        <= 4'd0;
            r_held_state <= ST_FWD;
            r_held_sense <= DIR_NONE;
            r_out_valid  <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_wr_dir     <= DIR_NONE;
            r_rev_pulse  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_auto_flag  <= n_auto_flag;
                r_mon        <= n_mon;
                r_last_host  <= n_last_host;
                r_last_acc   <= n_last_acc;
                r_last_rev   <= n_last_rev;
                r_act        <= n_act;
                r_app        <= n_app;
                r_edc        <= n_edc;
                r_held_state <= n_held_state;
                r_held_sense <= n_held_sense;
                r_wr_valid   <= n_wr_valid;
                r_wr_dir     <= n_wr_dir;
                r_rev_pulse  <= n_rev_pulse;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    `CDC_ASSERT(a_pulse_has_write, i_clk, i_rst_n, r_rev_pulse |-> (r_wr_valid && r_wr_dir == DIR_BWD), "reverse pulse without backward write-back")
    `CDC_ASSERT(a_write_dir_zero, i_clk, i_rst_n, !r_wr_valid |-> (r_wr_dir == DIR_NONE), "write direction set without write-back")
    `CDC_ASSERT(a_delay_in_bwd, i_clk, i_rst_n, (r_edc != 4'd0) |-> (r_app == DIR_BWD), "exit delay running outside backward")

endmodule

[rtl/core/charge_direction_controller.sv]
// A request accepted into the queue is popped by the back end, which registers
// its result onto the result port. Throughput: one request per cycle while the
// output is not stalled; the back end updates all direction state on each pop.
// A two-entry queue between classification and execution absorbs a stalled output.
// Reset (synchronous, active low) clears configuration to zero, empties the
// queue and returns the reported state to forward with the idle sense line.
module charge_direction_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [1:0]  i_host_direction,
    input  logic [15:0] i_input_volt,
    input  logic [15:0] i_output_volt,
    input  logic [15:0] i_accessory_volt,
    input  logic [15:0] i_remote_volt,
    input  logic        i_key_level,
    input  logic        i_timeout_lock,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_charge_state,
    output logic [1:0]  o_sense_select,
    output logic        o_write_valid,
    output logic [1:0]  o_write_direction,
    output logic        o_reverse_entered
);
    import cdc_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    assign o_in_stall = queue_full;

    cdc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_host_direction (i_host_direction),
        .i_input_volt     (i_input_volt),
        .i_output_volt    (i_output_volt),
        .i_accessory_volt (i_accessory_volt),
        .i_remote_volt    (i_remote_volt),
        .i_key_level      (i_key_level),
        .i_timeout_lock   (i_timeout_lock),
        .o_cmd            (front_cmd)
    );

    cdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_data  (queue_cmd)
    );

    cdc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (queue_empty),
        .i_cmd             (queue_cmd),
        .o_pop             (queue_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_charge_state    (o_charge_state),
        .o_sense_select    (o_sense_select),
        .o_write_valid     (o_write_valid),
        .o_write_direction (o_write_direction),
        .o_reverse_entered (o_reverse_entered)
    );

endmodule
